### design/health_table_retest_scheduler_defines.svh
// ----------------------------------------------------------------------------
// health_table_retest_scheduler_defines
// Assertion macros shared by the scheduler RTL. They expect i_clk and i_rst_n
// in the scope of the module that uses them.
// ----------------------------------------------------------------------------
`ifndef HEALTH_TABLE_RETEST_SCHEDULER_DEFINES_SVH
`define HEALTH_TABLE_RETEST_SCHEDULER_DEFINES_SVH
`ifndef SYNTHESIS
`define HTRS_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("assertion failed");
`define HTRS_ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error("forbidden condition");
`else
`define HTRS_ASSERT(lbl, prop)
`define HTRS_ASSERT_NEVER(lbl, cond)
`endif
`endif

### design/hts_pkg.sv
// ----------------------------------------------------------------------------
// hts_pkg
// Types and constants of the health table retest scheduler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package hts_pkg;
    localparam int ENTRIES   = 64;
    localparam int SLOT_W    = 6;
    localparam int BATCH_MAX = 50;
    localparam int CNT_W     = 6;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    localparam logic [1:0] FUNC_ADD    = 2'd0;
    localparam logic [1:0] FUNC_REPORT = 2'd1;
    localparam logic [1:0] FUNC_SELECT = 2'd2;
    localparam logic [1:0] FUNC_REMOVE = 2'd3;

    localparam logic [2:0] ST_ADDED    = 3'd0;
    localparam logic [2:0] ST_PROMOTED = 3'd1;
    localparam logic [2:0] ST_EXISTS   = 3'd2;
    localparam logic [2:0] ST_UPDATED  = 3'd3;
    localparam logic [2:0] ST_NOTFOUND = 3'd4;
    localparam logic [2:0] ST_REMOVED  = 3'd5;
    localparam logic [2:0] ST_SELECTED = 3'd6;

    localparam logic [1:0] CLS_NEW     = 2'd0;
    localparam logic [1:0] CLS_FLAGGED = 2'd1;
    localparam logic [1:0] CLS_STALE   = 2'd2;
    localparam logic [1:0] CLS_BACKOFF = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_BATCH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BOOST   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RECHECK = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MID     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_DEAD    = 3'd6;

    localparam logic [7:0] FAIL_MID  = 8'd5;
    localparam logic [7:0] FAIL_LONG = 8'd10;

    typedef struct packed {
        logic        alive;
        logic        flag;
        logic [7:0]  fail_run;
        logic [31:0] test_count;
        logic [31:0] pass_count;
        logic [15:0] latency;
        logic [31:0] created;
        logic [31:0] last_test;
        logic [31:0] last_alive;
        logic [31:0] boost_end;
    } t_rec;

    localparam int REC_W = $bits(t_rec);

    typedef struct packed {
        logic [5:0]  batch_limit;
        logic [15:0] boost;
        logic [15:0] recheck;
        logic [15:0] back_short;
        logic [15:0] back_mid;
        logic [15:0] back_long;
        logic [7:0]  dead_limit;
    } t_cfg;

    typedef struct packed {
        logic        due;
        logic [1:0]  cls;
        logic        boosted;
        logic [31:0] tests;
    } t_cand;

    typedef struct packed {
        logic              re;
        logic [SLOT_W-1:0] raddr;
        logic              we;
        logic [SLOT_W-1:0] waddr;
    } t_mem_cmd;

    typedef struct packed {
        logic [2:0]        status;
        logic [SLOT_W-1:0] slot;
        logic [1:0]        cls;
        logic              boosted;
        logic [31:0]       tests;
    } t_rsp;
endpackage
`default_nettype wire

### design/hts_if.sv
// ----------------------------------------------------------------------------
// hts_if
// Request, result and configuration channels with valid/ready transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
interface hts_req_if;
    import hts_pkg::*;
    logic              valid;
    logic              ready;
    logic [1:0]        func;
    logic [SLOT_W-1:0] slot_index;
    logic [31:0]       now_seconds;
    logic              urgent;
    logic              test_passed;
    logic              declare_dead;
    logic [15:0]       measured_latency;
    modport source (output valid, func, slot_index, now_seconds, urgent,
                    test_passed, declare_dead, measured_latency, input ready);
    modport sink (input valid, func, slot_index, now_seconds, urgent,
                  test_passed, declare_dead, measured_latency, output ready);
endinterface

interface hts_rsp_if;
    import hts_pkg::*;
    logic              valid;
    logic              ready;
    logic [2:0]        status;
    logic [SLOT_W-1:0] result_slot;
    logic [1:0]        priority_class;
    logic              is_boosted;
    logic [31:0]       tests_so_far;
    logic              last_of_run;
    modport source (output valid, status, result_slot, priority_class, is_boosted,
                    tests_so_far, last_of_run, input ready);
    modport sink (input valid, status, result_slot, priority_class, is_boosted,
                  tests_so_far, last_of_run, output ready);
endinterface

interface hts_cfg_if;
    import hts_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

### design/hts_ram.sv
// ----------------------------------------------------------------------------
// hts_ram
// Simple dual-port synchronous RAM, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module hts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire [$clog2(DEPTH)-1:0] i_waddr,
    input  wire [WIDTH-1:0]         i_wdata,
    input  wire                     i_re,
    input  wire [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]        o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

### design/hts_rank.sv
// ----------------------------------------------------------------------------
// hts_rank
// Classifies one record for retest: due flag, class, boost state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module hts_rank (
    input  wire hts_pkg::t_rec i_rec,
    input  wire                i_en,
    input  wire [31:0]         i_now,
    input  wire hts_pkg::t_cfg i_cfg,
    output hts_pkg::t_cand     o_cand
);
    import hts_pkg::*;

    logic [32:0] w_alive_lim;
    logic [32:0] w_fail_lim;
    logic [15:0] w_wait;

    always_comb begin
        if (i_rec.fail_run >= FAIL_LONG) begin
            w_wait = i_cfg.back_long;
        end else if (i_rec.fail_run >= FAIL_MID) begin
            w_wait = i_cfg.back_mid;
        end else begin
            w_wait = i_cfg.back_short;
        end
        w_alive_lim = {1'b0, i_rec.last_test} + {17'd0, i_cfg.recheck};
        w_fail_lim  = {1'b0, i_rec.last_test} + {17'd0, w_wait};

        o_cand.boosted = i_rec.boost_end > i_now;
        o_cand.tests   = i_rec.test_count;
        o_cand.cls     = CLS_NEW;
        o_cand.due     = 1'b0;
        if (i_rec.test_count == 32'd0) begin
            o_cand.due = 1'b1;
        end else if (i_rec.flag) begin
            o_cand.cls = CLS_FLAGGED;
            o_cand.due = 1'b1;
        end else if (i_rec.alive) begin
            o_cand.cls = CLS_STALE;
            o_cand.due = {1'b0, i_now} > w_alive_lim;
        end else if (i_rec.fail_run != 8'd0) begin
            o_cand.cls = CLS_BACKOFF;
            o_cand.due = {1'b0, i_now} > w_fail_lim;
        end
        o_cand.due = o_cand.due & i_en;
    end
endmodule
`default_nettype wire

### design/hts_ctrl.sv
// ----------------------------------------------------------------------------
// hts_ctrl
// Operation sequencer: read-modify-write of records, select scan, results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "health_table_retest_scheduler_defines.svh"
module hts_ctrl (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire hts_pkg::t_cfg i_cfg,
    hts_req_if.sink            i_req,
    hts_rsp_if.source          o_rsp,
    output hts_pkg::t_mem_cmd  o_mem,
    output hts_pkg::t_rec      o_wdata,
    input  wire hts_pkg::t_rec i_rdata
);
    import hts_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_OP     = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_DECIDE = 3'd3;
    localparam logic [2:0] S_FLUSH  = 3'd4;

    logic [2:0]        r_state;
    logic [1:0]        r_func;
    logic [SLOT_W-1:0] r_slot;
    logic [31:0]       r_now;
    logic              r_hp;
    logic              r_pass;
    logic              r_dead;
    logic [15:0]       r_lat;
    logic [ENTRIES-1:0] r_valid;
    logic [ENTRIES-1:0] r_picked;
    logic [SLOT_W:0]   r_ra;
    logic              r_dv;
    logic [SLOT_W-1:0] r_dslot;
    logic              r_best_v;
    logic [34:0]       r_best_key;
    t_rsp              r_best;
    logic              r_pend_v;
    t_rsp              r_pend;
    logic [CNT_W-1:0]  r_cnt;
    logic [CNT_W-1:0]  r_limit;
    logic              r_out_v;
    t_rsp              r_out;
    logic              r_out_last;

    logic              w_accept;
    logic              w_out_free;
    logic [CNT_W-1:0]  w_lim;
    logic              w_cur_valid;
    t_rec              w_rec;
    t_cand             w_cand;
    logic [34:0]       w_key;
    logic              w_take;
    t_rec              n_rec;
    logic [2:0]        n_status;
    logic              n_we;
    logic [32:0]       w_end;
    logic [31:0]       w_until;
    logic [7:0]        w_fail;
    logic [CNT_W-1:0]  n_cnt;

    assign w_accept   = i_req.valid && (r_state == S_IDLE);
    assign i_req.ready = (r_state == S_IDLE);
    assign w_out_free = !r_out_v || o_rsp.ready;
    assign w_lim = (i_cfg.batch_limit > CNT_W'(BATCH_MAX)) ? CNT_W'(BATCH_MAX)
                                                          : i_cfg.batch_limit;
    assign n_cnt = r_cnt + 1'b1;

    assign w_cur_valid = (r_state == S_SCAN) ? (r_valid[r_dslot] && !r_picked[r_dslot])
                                             : r_valid[r_slot];
    assign w_rec = w_cur_valid ? i_rdata : '0;

    hts_rank u_rank (
        .i_rec  (w_rec),
        .i_en   (w_cur_valid),
        .i_now  (r_now),
        .i_cfg  (i_cfg),
        .o_cand (w_cand)
    );

    assign w_key  = {!w_cand.boosted, w_cand.cls, w_cand.tests};
    assign w_take = r_dv && w_cand.due && (!r_best_v || (w_key < r_best_key));

    // record update for add, report, remove
    always_comb begin
        w_end   = {1'b0, r_now} + {17'd0, i_cfg.boost};
        w_until = w_end[32] ? 32'hFFFF_FFFF : w_end[31:0];
        if (r_dead) begin
            w_fail = i_cfg.dead_limit;
        end else if (w_rec.fail_run != 8'hFF) begin
            w_fail = w_rec.fail_run + 8'd1;
        end else begin
            w_fail = w_rec.fail_run;
        end
        n_rec    = w_rec;
        n_we     = 1'b0;
        n_status = ST_NOTFOUND;
        case (r_func)
            FUNC_ADD: begin
                if (w_cur_valid) begin
                    if (r_hp) begin
                        n_we     = 1'b1;
                        n_status = ST_PROMOTED;
                        n_rec.flag = 1'b1;
                        if (w_until > w_rec.boost_end) begin
                            n_rec.boost_end = w_until;
                        end
                    end else begin
                        n_status = ST_EXISTS;
                    end
                end else begin
                    n_we       = 1'b1;
                    n_status   = ST_ADDED;
                    n_rec      = '0;
                    n_rec.flag = 1'b1;
                    n_rec.created   = r_now;
                    n_rec.boost_end = r_hp ? w_until : 32'd0;
                end
            end
            FUNC_REPORT: begin
                if (w_cur_valid) begin
                    n_we      = 1'b1;
                    n_status  = ST_UPDATED;
                    n_rec.last_test = r_now;
                    if (w_rec.test_count != 32'hFFFF_FFFF) begin
                        n_rec.test_count = w_rec.test_count + 32'd1;
                    end
                    n_rec.flag      = 1'b0;
                    n_rec.boost_end = 32'd0;
                    if (r_pass) begin
                        n_rec.alive    = 1'b1;
                        n_rec.latency  = r_lat;
                        n_rec.fail_run = 8'd0;
                        if (w_rec.pass_count != 32'hFFFF_FFFF) begin
                            n_rec.pass_count = w_rec.pass_count + 32'd1;
                        end
                        n_rec.last_alive = r_now;
                    end else begin
                        n_rec.fail_run = w_fail;
                        if (w_fail >= i_cfg.dead_limit) begin
                            n_rec.alive   = 1'b0;
                            n_rec.latency = 16'd0;
                        end
                    end
                end
            end
            FUNC_REMOVE: begin
                if (w_cur_valid) begin
                    n_status = ST_REMOVED;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_mem.re    = 1'b0;
        o_mem.raddr = i_req.slot_index;
        if (w_accept) begin
            o_mem.re = 1'b1;
        end else if (r_state == S_SCAN && !r_ra[SLOT_W]) begin
            o_mem.re    = 1'b1;
            o_mem.raddr = r_ra[SLOT_W-1:0];
        end
        o_mem.we    = (r_state == S_OP) && w_out_free && n_we;
        o_mem.waddr = r_slot;
    end
    assign o_wdata = n_rec;

    assign o_rsp.valid          = r_out_v;
    assign o_rsp.status         = r_out.status;
    assign o_rsp.result_slot    = r_out.slot;
    assign o_rsp.priority_class = r_out.cls;
    assign o_rsp.is_boosted     = r_out.boosted;
    assign o_rsp.tests_so_far   = r_out.tests;
    assign o_rsp.last_of_run    = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_valid  <= '0;
            r_picked <= '0;
            r_out_v  <= 1'b0;
            r_pend_v <= 1'b0;
            r_dv     <= 1'b0;
            r_best_v <= 1'b0;
            r_cnt    <= '0;
            r_limit  <= '0;
            r_ra     <= '0;
        end else begin
            if (o_rsp.ready) begin
                r_out_v <= 1'b0;
            end
            r_dv <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_func <= i_req.func;
                        r_slot <= i_req.slot_index;
                        r_now  <= i_req.now_seconds;
                        r_hp   <= i_req.urgent;
                        r_pass <= i_req.test_passed;
                        r_dead <= i_req.declare_dead;
                        r_lat  <= i_req.measured_latency;
                        if (i_req.func == FUNC_SELECT) begin
                            r_limit  <= w_lim;
                            r_cnt    <= '0;
                            r_picked <= '0;
                            r_pend_v <= 1'b0;
                            r_ra     <= '0;
                            r_best_v <= 1'b0;
                            if (w_lim != '0) begin
                                r_state <= S_SCAN;
                            end
                        end else begin
                            r_state <= S_OP;
                        end
                    end
                end
                S_OP: begin
                    if (w_out_free) begin
                        r_out_v    <= 1'b1;
                        r_out      <= '{status: n_status, slot: r_slot, cls: CLS_NEW,
                                        boosted: 1'b0, tests: 32'd0};
                        r_out_last <= 1'b1;
                        if (r_func == FUNC_ADD && n_status == ST_ADDED) begin
                            r_valid[r_slot] <= 1'b1;
                        end
                        if (n_status == ST_REMOVED) begin
                            r_valid[r_slot] <= 1'b0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                S_SCAN: begin
                    if (!r_ra[SLOT_W]) begin
                        r_ra    <= r_ra + 1'b1;
                        r_dv    <= 1'b1;
                        r_dslot <= r_ra[SLOT_W-1:0];
                    end
                    if (w_take) begin
                        r_best_v   <= 1'b1;
                        r_best_key <= w_key;
                        r_best     <= '{status: ST_SELECTED, slot: r_dslot, cls: w_cand.cls,
                                        boosted: w_cand.boosted, tests: w_cand.tests};
                    end
                    if (r_ra[SLOT_W] && !r_dv) begin
                        r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    if (!r_pend_v || w_out_free) begin
                        if (r_pend_v) begin
                            r_out_v    <= 1'b1;
                            r_out      <= r_pend;
                            r_out_last <= !r_best_v;
                        end
                        if (r_best_v) begin
                            r_pend_v <= 1'b1;
                            r_pend   <= r_best;
                            r_picked[r_best.slot] <= 1'b1;
                            r_cnt    <= n_cnt;
                            r_best_v <= 1'b0;
                            r_ra     <= '0;
                            r_state  <= (n_cnt == r_limit) ? S_FLUSH : S_SCAN;
                        end else begin
                            r_pend_v <= 1'b0;
                            r_state  <= S_IDLE;
                        end
                    end
                end
                S_FLUSH: begin
                    if (w_out_free) begin
                        r_out_v    <= 1'b1;
                        r_out      <= r_pend;
                        r_out_last <= 1'b1;
                        r_pend_v   <= 1'b0;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `HTRS_ASSERT_NEVER(a_pend_in_idle, (r_state == S_IDLE) && r_pend_v)
    `HTRS_ASSERT_NEVER(a_cnt_over_limit, (r_state != S_IDLE) && (r_cnt > r_limit))
    `HTRS_ASSERT(a_pick_count, (r_state == S_SCAN) |-> ($countones(r_picked) == r_cnt))
    `HTRS_ASSERT_NEVER(a_write_outside_op, o_mem.we && (r_state != S_OP))
endmodule
`default_nettype wire

### design/health_table_retest_scheduler.sv
// ----------------------------------------------------------------------------
// health_table_retest_scheduler
// Endpoint health table with add, report, select and remove operations.
// ----------------------------------------------------------------------------
// Add, report and remove read the slot's record from the table RAM in the
// accept cycle and write it back from the operate state once the result
// channel can take the result. Select makes one full pass over the 64-entry
// table for each entry it picks, plus one pass that finds nothing when fewer
// entries than the batch limit are due. A pass reads all 64 entries, empties
// the read pipeline and then commits the pick; a select picks at most 50
// entries, and result stalls add to its run. The single RAM read port is why
// each pick needs a full pass over the table.
// Records come out of reset empty with no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module health_table_retest_scheduler (
    input  wire        i_clk,
    input  wire        i_rst_n,
    hts_req_if.sink    i_req,
    hts_rsp_if.source  o_rsp,
    hts_cfg_if.sink    i_cfg
);
    import hts_pkg::*;

    t_cfg             r_cfg;
    t_mem_cmd         w_mem;
    t_rec             w_wdata;
    t_rec             w_rdata;
    logic [REC_W-1:0] w_rdata_raw;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{batch_limit: 6'd50, boost: 16'd1800, recheck: 16'd30,
                       back_short: 16'd60, back_mid: 16'd300, back_long: 16'd1800,
                       dead_limit: 8'd3};
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_BATCH:   r_cfg.batch_limit <= i_cfg.data[5:0];
                CFG_BOOST:   r_cfg.boost       <= i_cfg.data;
                CFG_RECHECK: r_cfg.recheck     <= i_cfg.data;
                CFG_SHORT:   r_cfg.back_short  <= i_cfg.data;
                CFG_MID:     r_cfg.back_mid    <= i_cfg.data;
                CFG_LONG:    r_cfg.back_long   <= i_cfg.data;
                CFG_DEAD:    r_cfg.dead_limit  <= i_cfg.data[7:0];
                default: begin
                end
            endcase
        end
    end

    hts_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_req   (i_req),
        .o_rsp   (o_rsp),
        .o_mem   (w_mem),
        .o_wdata (w_wdata),
        .i_rdata (w_rdata)
    );

    hts_ram #(
        .WIDTH (REC_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_mem.we),
        .i_waddr (w_mem.waddr),
        .i_wdata (w_wdata),
        .i_re    (w_mem.re),
        .i_raddr (w_mem.raddr),
        .o_rdata (w_rdata_raw)
    );

    assign w_rdata = w_rdata_raw;
endmodule
`default_nettype wire
